// ----- rtl/btrb_pkg.sv -----
`default_nettype none

package btrb_pkg;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // Cause classes
    localparam logic [3:0] CAUSE_NONE    = 4'd0;
    localparam logic [3:0] CAUSE_TRAP    = 4'd1;
    localparam logic [3:0] CAUSE_INT     = 4'd2;
    localparam logic [3:0] CAUSE_RESET   = 4'd3;
    localparam logic [3:0] CAUSE_NMI     = 4'd4;
    localparam logic [3:0] CAUSE_ADTRAP  = 4'd5;
    localparam logic [3:0] CAUSE_ILLEGAL = 4'd6;
    localparam logic [3:0] CAUSE_ZDIV    = 4'd7;
    localparam logic [3:0] CAUSE_FIV     = 4'd8;
    localparam logic [3:0] CAUSE_FZD     = 4'd9;
    localparam logic [3:0] CAUSE_FOV     = 4'd10;
    localparam logic [3:0] CAUSE_FUD     = 4'd11;
    localparam logic [3:0] CAUSE_FPR     = 4'd12;
    localparam logic [3:0] CAUSE_FRO     = 4'd13;
    localparam logic [3:0] CAUSE_OTHER   = 4'd14;

    // Input mode codes
    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_DUMP   = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] from_addr;
        logic [31:0] to_addr;
        logic [15:0] exception_code;
    } in_req_t;

    typedef struct packed {
        logic [31:0] entry_from;
        logic [31:0] entry_to;
        logic [15:0] entry_code;
        logic [31:0] repeat_count;
        logic [3:0]  cause_class;
        logic [3:0]  int_level;
        logic        last;
    } out_req_t;

    // One trace entry as held by a cell
    typedef struct packed {
        logic        valid;
        logic [31:0] from_addr;
        logic [31:0] to_addr;
        logic [15:0] code;
        logic [31:0] count;
    } cell_t;

    typedef struct packed {
        logic clear;
        logic shift;
        logic inc;
    } cell_ctrl_t;

    function automatic logic [3:0] cause_of(input logic [15:0] code);
        logic [3:0] cls;
        cls = CAUSE_OTHER;
        if (code inside {[16'hFFA0:16'hFFBF]})
            cls = CAUSE_TRAP;
        else if (code inside {[16'hFE00:16'hFEFF]})
            cls = CAUSE_INT;
        else
        begin
            case (code)
                16'h0000: cls = CAUSE_NONE;
                16'hFFF0: cls = CAUSE_RESET;
                16'hFFD0: cls = CAUSE_NMI;
                16'hFFC0: cls = CAUSE_ADTRAP;
                16'hFF90: cls = CAUSE_ILLEGAL;
                16'hFF80: cls = CAUSE_ZDIV;
                16'hFF70: cls = CAUSE_FIV;
                16'hFF68: cls = CAUSE_FZD;
                16'hFF64: cls = CAUSE_FOV;
                16'hFF62: cls = CAUSE_FUD;
                16'hFF61: cls = CAUSE_FPR;
                16'hFF60: cls = CAUSE_FRO;
                default:  cls = CAUSE_OTHER;
            endcase
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/btrb_cell.sv -----
`default_nettype none

module btrb_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire btrb_pkg::cell_ctrl_t ctrl,
    input  wire btrb_pkg::cell_t      d,
    output btrb_pkg::cell_t           q
);
    import btrb_pkg::*;

    logic        valid_reg;
    logic [31:0] from_reg;
    logic [31:0] to_reg;
    logic [15:0] code_reg;
    logic [31:0] count_reg;

    // valid: clear wins, shift takes the neighbor's bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctrl.clear)
            valid_reg <= 1'b0;
        else if (ctrl.shift)
            valid_reg <= d.valid;
    end

    always_ff @(posedge clk)
    begin
        if (!ctrl.clear && ctrl.shift)
        begin
            from_reg  <= d.from_addr;
            to_reg    <= d.to_addr;
            code_reg  <= d.code;
            count_reg <= d.count;
        end
        else if (!ctrl.clear && ctrl.inc)
            count_reg <= count_reg + 32'd1;
    end

    assign q = '{valid: valid_reg, from_addr: from_reg, to_addr: to_reg,
                 code: code_reg, count: count_reg};

endmodule

`default_nettype wire

// ----- rtl/branch_trace_ring_buffer_top.sv -----
`default_nettype none

// Branch trace ring: DEPTH cells in a row, cell 0 the newest entry, the far
// cell the oldest. A record request that matches the newest valid entry (and
// whose count is not saturated) bumps cell 0's count; any other record
// request shifts the whole row by one and enters a new entry with count 1 at
// cell 0, dropping the oldest. Records are taken one per cycle while no dump
// is in progress and are ignored while trace_enable is 0. A dump request
// rotates the row through all DEPTH positions, one per cycle while the output
// is not stalled, emitting each valid entry as it passes the oldest cell, so
// entries come out oldest first and the row ends where it started. A dump
// holds the input stalled until its rotation ends; an empty trace dumps with
// no output. Writing 0 to trace_enable clears every valid bit; writing 1
// keeps entries. Reset leaves the trace empty at once, no clearing pass.

module branch_trace_ring_buffer_top #(
    parameter int DEPTH = 24
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire btrb_pkg::in_req_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output btrb_pkg::out_req_t     out_data
);
    import btrb_pkg::*;

    localparam int SW = $clog2(DEPTH);
    localparam logic [SW-1:0] STEP_LAST = SW'(DEPTH - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic          state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;
    logic          enable_reg;
    logic          out_valid_reg, out_valid_next;
    out_req_t      out_data_reg;

    cell_t      cell_q [DEPTH];
    cell_t      cell_d [DEPTH];
    cell_ctrl_t cell_ctrl [DEPTH];

    logic  in_acc, rec, dump_start, step, match, out_free, emit;
    cell_t new_entry, tap;
    logic [3:0] tap_cls;

    assign tap = cell_q[DEPTH-1];   // oldest cell is the dump tap

    assign in_stall   = (state_reg == ST_DUMP);
    assign in_acc     = in_valid && !in_stall;
    assign rec        = in_acc && (in_data.mode == MODE_RECORD) && enable_reg;
    assign dump_start = in_acc && (in_data.mode == MODE_DUMP);
    assign out_free   = !out_valid_reg || !out_stall;
    assign step       = (state_reg == ST_DUMP) && out_free;
    assign emit       = step && tap.valid;

    // fold into newest entry?
    assign match = cell_q[0].valid
                && (cell_q[0].from_addr == in_data.from_addr)
                && (cell_q[0].to_addr == in_data.to_addr)
                && (cell_q[0].code == in_data.exception_code)
                && (cell_q[0].count != COUNT_MAX);

    assign new_entry = '{valid: 1'b1, from_addr: in_data.from_addr,
                         to_addr: in_data.to_addr, code: in_data.exception_code,
                         count: 32'd1};

    // Cell row: during a dump the row rotates, the oldest wrapping to cell 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign cell_d[i] = step ? tap : new_entry;
        end
        else
        begin : g_body
            assign cell_d[i] = cell_q[i-1];
        end

        assign cell_ctrl[i] = '{clear: cfg_we && !cfg_data,
                                shift: (rec && !match) || step,
                                inc:   (i == 0) && rec && match};

        btrb_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .ctrl (cell_ctrl[i]),
            .d    (cell_d[i]),
            .q    (cell_q[i])
        );
    end

    // Dump sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (dump_start)
                begin
                    state_next = ST_DUMP;
                    step_next  = '0;
                end
            end
            ST_DUMP:
            begin
                if (step)
                begin
                    step_next = step_reg + SW'(1);
                    if (step_reg == STEP_LAST)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            enable_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                enable_reg <= cfg_data;
        end
    end

    assign tap_cls = cause_of(tap.code);

    // Output register; newest entry passes the tap on the final step
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.entry_from   <= tap.from_addr;
            out_data_reg.entry_to     <= tap.to_addr;
            out_data_reg.entry_code   <= tap.code;
            out_data_reg.repeat_count <= tap.count;
            out_data_reg.cause_class  <= tap_cls;
            out_data_reg.int_level    <= (tap_cls == CAUSE_INT) ? tap.code[7:4] : 4'd0;
            out_data_reg.last         <= (step_reg == STEP_LAST);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/btrb_checker.sv -----
`default_nettype none

module btrb_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire btrb_pkg::in_req_t  in_data,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire btrb_pkg::out_req_t out_data
);
    import btrb_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output request changed");

    // a dump request locks out input on the next cycle
    a_dump_locks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.mode == MODE_DUMP) |=> in_stall)
        else $error("dump request did not stall input");

    // results only come out of a dump in progress
    a_out_from_dump: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid) |-> $past(in_stall))
        else $error("output request not caused by a dump");

    // a record request never produces a result
    a_record_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.mode == MODE_RECORD) && !out_valid
        |=> !out_valid)
        else $error("record request produced output");

endmodule

bind branch_trace_ring_buffer_top btrb_checker u_btrb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);

`default_nettype wire

// ----- tb/sv/btrb_trace_checker.sv -----
// Watches both channels of the branch trace ring, keeps its own copy of the
// trace store and compares each dumped entry against the oldest expected one.

module btrb_trace_checker #(
    parameter int DEPTH = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_data,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire btrb_pkg::in_req_t  in_data,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire btrb_pkg::out_req_t out_data,
    output int                      fail_count,
    output int                      pending,
    output int                      requests,
    output int                      entries_checked,
    output int                      folds,
    output int                      overwrites
);

    import btrb_pkg::*;

    logic [31:0] src_mem   [DEPTH];
    logic [31:0] dst_mem   [DEPTH];
    logic [15:0] code_mem  [DEPTH];
    logic [31:0] count_mem [DEPTH];
    logic        valid_mem [DEPTH];
    int          wptr;
    logic        tracing;
    out_req_t    expected_entries [$];

    function automatic void clear_trace();
        int i;
        for (i = 0; i < DEPTH; i++)
        begin
            src_mem[i]   = '0;
            dst_mem[i]   = '0;
            code_mem[i]  = '0;
            count_mem[i] = '0;
            valid_mem[i] = 1'b0;
        end
        wptr = 0;
    endfunction

    function automatic logic [3:0] class_of(input logic [15:0] c);
        if (c >= 16'hFFA0 && c <= 16'hFFBF)
            return CAUSE_TRAP;
        if (c >= 16'hFE00 && c <= 16'hFEFF)
            return CAUSE_INT;
        case (c)
            16'h0000: return CAUSE_NONE;
            16'hFFF0: return CAUSE_RESET;
            16'hFFD0: return CAUSE_NMI;
            16'hFFC0: return CAUSE_ADTRAP;
            16'hFF90: return CAUSE_ILLEGAL;
            16'hFF80: return CAUSE_ZDIV;
            16'hFF70: return CAUSE_FIV;
            16'hFF68: return CAUSE_FZD;
            16'hFF64: return CAUSE_FOV;
            16'hFF62: return CAUSE_FUD;
            16'hFF61: return CAUSE_FPR;
            16'hFF60: return CAUSE_FRO;
            default:  return CAUSE_OTHER;
        endcase
    endfunction

    // Fold into the newest entry when identical and not saturated,
    // else take a fresh slot at the write pointer.
    function automatic void record_transfer(input logic [31:0] src, input logic [31:0] dst,
                                            input logic [15:0] code);
        int prev;
        prev = (wptr + DEPTH - 1) % DEPTH;
        if (valid_mem[prev] && src_mem[prev] == src && dst_mem[prev] == dst &&
            code_mem[prev] == code && count_mem[prev] != COUNT_MAX)
        begin
            count_mem[prev] = count_mem[prev] + 32'd1;
            folds++;
        end
        else
        begin
            if (valid_mem[wptr])
                overwrites++;
            src_mem[wptr]   = src;
            dst_mem[wptr]   = dst;
            code_mem[wptr]  = code;
            count_mem[wptr] = 32'd1;
            valid_mem[wptr] = 1'b1;
            wptr = (wptr + 1) % DEPTH;
        end
    endfunction

    function automatic void queue_dump();
        out_req_t e;
        int       x;
        int       i;
        int       newest;
        newest = -1;
        for (x = 0; x < DEPTH; x++)
        begin
            if (valid_mem[(x + wptr) % DEPTH])
                newest = x;
        end
        for (x = 0; x < DEPTH; x++)
        begin
            i = (x + wptr) % DEPTH;
            if (valid_mem[i])
            begin
                e.entry_from   = src_mem[i];
                e.entry_to     = dst_mem[i];
                e.entry_code   = code_mem[i];
                e.repeat_count = count_mem[i];
                e.cause_class  = class_of(code_mem[i]);
                e.int_level    = (e.cause_class == CAUSE_INT) ? code_mem[i][7:4] : 4'd0;
                e.last         = (x == newest);
                expected_entries.insert(expected_entries.size(), e);
            end
        end
    endfunction

    function automatic void check_entry(input out_req_t got);
        out_req_t exp_e;
        logic     bad;
        if (expected_entries.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("btrb_checker: unexpected entry from=%h to=%h code=%h cnt=%h",
                         got.entry_from, got.entry_to, got.entry_code, got.repeat_count);
        end
        else
        begin
            exp_e = expected_entries.pop_front();
            entries_checked++;
            bad = (got.entry_from   !== exp_e.entry_from)   ||
                  (got.entry_to     !== exp_e.entry_to)     ||
                  (got.entry_code   !== exp_e.entry_code)   ||
                  (got.repeat_count !== exp_e.repeat_count) ||
                  (got.cause_class  !== exp_e.cause_class)  ||
                  (got.int_level    !== exp_e.int_level)    ||
                  (got.last         !== exp_e.last);
            if (bad)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("btrb_checker: exp from=%h to=%h code=%h cnt=%h cls=%0d lvl=%0d last=%b",
                             exp_e.entry_from, exp_e.entry_to, exp_e.entry_code,
                             exp_e.repeat_count, exp_e.cause_class, exp_e.int_level, exp_e.last);
                    $display("btrb_checker: got from=%h to=%h code=%h cnt=%h cls=%0d lvl=%0d last=%b",
                             got.entry_from, got.entry_to, got.entry_code,
                             got.repeat_count, got.cause_class, got.int_level, got.last);
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_trace();
            tracing = 1'b0;
            expected_entries.delete();
            fail_count      = 0;
            pending         = 0;
            requests        = 0;
            entries_checked = 0;
            folds           = 0;
            overwrites      = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                tracing = cfg_data;
                if (!cfg_data)
                    clear_trace();
            end
            if (in_valid && !in_stall)
            begin
                requests++;
                if (in_data.mode == MODE_DUMP)
                    queue_dump();
                else if (tracing)
                    record_transfer(in_data.from_addr, in_data.to_addr, in_data.exception_code);
            end
            if (out_valid && !out_stall)
                check_entry(out_data);
            pending = expected_entries.size();
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the branch trace ring testbench.
//
// The top only makes stimulus and gives the verdict; btrb_trace_checker sits
// beside the block, predicts every dumped entry and counts mismatches.
// Stimulus: a short directed run (disabled records and dumps, folding of
// identical transfers, address extremes, records of every cause class, enable
// rewrite that keeps entries, disable that clears), then random phases with
// different enable settings, dump and repeat mixes, idle gaps on both sides,
// and one phase where the receiver holds off long enough that a dump backs up
// and the block stalls its input.

module tb_top;

    import btrb_pkg::*;

    localparam int DEPTH       = 24;
    localparam int IDLE_LIMIT  = 2000;   // cycles with no accepted request
    localparam int HOLD_CYCLES = 300;    // the one long receiver hold-off
    localparam int SETTLE      = 2 * DEPTH + 4;  // margin for a full dump rotation

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cfg_we    = 1'b0;
    logic     cfg_data  = 1'b0;
    logic     in_valid  = 1'b0;
    in_req_t  in_data   = '0;
    logic     out_stall = 1'b0;
    logic     in_stall;
    logic     out_valid;
    out_req_t out_data;

    // Receiver controls, driven from the stimulus process at falling edges
    logic     rx_quiet  = 1'b0;
    logic     hold_arm  = 1'b0;
    bit       tx_quiet  = 1'b0;

    int       fail_count;
    int       pending;
    int       requests;
    int       entries_checked;
    int       folds;
    int       overwrites;

    int       idle_cycles = 0;
    int       hold_left   = 0;
    int       stall_left  = 0;
    bit       hold_done   = 1'b0;

    // Codes for every cause class but NONE and OTHER, including both ends of the trap and interrupt ranges
    logic [15:0] cause_codes [0:15] = '{
        16'hFFA0, 16'hFFBF, 16'hFE00, 16'hFEFF, 16'hFE5A, 16'hFFF0, 16'hFFD0, 16'hFFC0,
        16'hFF90, 16'hFF80, 16'hFF70, 16'hFF68, 16'hFF64, 16'hFF62, 16'hFF61, 16'hFF60
    };

    always #6 clk = ~clk;

    branch_trace_ring_buffer_top #(
        .DEPTH (DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    btrb_trace_checker #(
        .DEPTH (DEPTH)
    ) trace_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .requests        (requests),
        .entries_checked (entries_checked),
        .folds           (folds),
        .overwrites      (overwrites)
    );

    // Gap length: mostly short, a few long
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [31:0] pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 32'h0000_0000;
        if (r < 16)
            return 32'hFFFF_FFFF;
        if (r < 30)
            return $urandom_range(0, 255);
        return $urandom;
    endfunction

    // Plain branches, trap/interrupt ranges, exact class codes, anything else
    function automatic logic [15:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return 16'h0000;
        if (r < 45)
            return 16'hFFA0 + 16'($urandom_range(0, 31));
        if (r < 60)
            return 16'hFE00 + 16'($urandom_range(0, 255));
        if (r < 82)
            return cause_codes[4'($urandom_range(0, 15))];
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic in_req_t make_record(input logic [31:0] src, input logic [31:0] dst,
                                            input logic [15:0] code);
        in_req_t r;
        r.mode           = MODE_RECORD;
        r.from_addr      = src;
        r.to_addr        = dst;
        r.exception_code = code;
        return r;
    endfunction

    // Dump payload fields are don't-care; fill them with noise
    function automatic in_req_t make_dump();
        in_req_t r;
        r.mode           = MODE_DUMP;
        r.from_addr      = $urandom;
        r.to_addr        = $urandom;
        r.exception_code = 16'($urandom_range(0, 65535));
        return r;
    endfunction

    // Offer one request after an optional gap; returns at the falling edge
    // after it was taken. Valid stays high when the next request follows.
    task automatic send_request(input in_req_t r);
        int gap;
        if (tx_quiet || $urandom_range(0, 1) == 0)
            gap = 0;
        else
            gap = pick_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Register writes only with the block idle: nothing expected, and a
    // full dump rotation allowed to finish (empty dumps leave no trace).
    task automatic set_trace(input logic on);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= on;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // One random phase. Most requests are records, some exact repeats of
    // the newest transfer (fold), some repeats of an older one (no fold),
    // with dumps sprinkled in; every phase ends with a dump. A squeeze
    // phase forces a dump right after the hold-off starts.
    task automatic run_phase(input logic on, input int n, input int dump_pct,
                             input int fold_pct, input bit quiet, input bit squeeze);
        in_req_t newest;
        in_req_t older;
        int      k;
        int      roll;
        set_trace(on);
        tx_quiet = quiet;
        rx_quiet <= quiet;
        newest = make_record(pick_addr(), pick_addr(), pick_code());
        older  = newest;
        for (k = 0; k < n; k++)
        begin
            if (squeeze && k == 4)
                hold_arm <= 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < dump_pct || (squeeze && k == 5))
                send_request(make_dump());
            else if (roll < dump_pct + fold_pct)
                send_request(newest);
            else if (roll < dump_pct + fold_pct + 5)
                send_request(older);
            else
            begin
                older  = newest;
                newest = make_record(pick_addr(), pick_addr(), pick_code());
                send_request(newest);
            end
        end
        send_request(make_dump());
    endtask

    // Receiver: random stalls, plus the single long hold-off once armed
    always @(negedge clk)
    begin
        if (hold_arm && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!rx_quiet && $urandom_range(0, 99) < 25)
        begin
            stall_left = pick_len() - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog: too long without any request accepted on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        int k;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Disabled after reset: records ignored, dumps empty
        send_request(make_dump());
        send_request(make_record($urandom, $urandom, 16'h0000));
        send_request(make_dump());

        set_trace(1'b1);
        // Identical transfer twice folds into one entry with count 2
        send_request(make_record(32'h0000_0000, 32'h0000_0000, 16'h0000));
        send_request(make_record(32'h0000_0000, 32'h0000_0000, 16'h0000));
        send_request(make_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        for (k = 0; k < 16; k++)
            send_request(make_record($urandom, $urandom, cause_codes[k]));
        send_request(make_dump());

        // Rewriting enable keeps the entries
        set_trace(1'b1);
        send_request(make_dump());

        // Disable clears the store
        set_trace(1'b0);
        send_request(make_dump());

        // Random phases: on, n, dump%, fold%, no idling, long hold-off
        run_phase(1'b1, 40, 12, 25, 1'b0, 1'b0);
        run_phase(1'b1, 45,  4,  8, 1'b0, 1'b0);   // wraps the ring
        run_phase(1'b0,  8, 30, 20, 1'b0, 1'b0);
        run_phase(1'b0,  6, 30, 20, 1'b0, 1'b0);   // clear while already off
        run_phase(1'b1, 45, 25, 20, 1'b0, 1'b1);   // receiver holds off
        run_phase(1'b1, 40, 10, 30, 1'b1, 1'b0);   // back to back
        run_phase(1'b1, 35, 15, 40, 1'b0, 1'b0);
        run_phase(1'b0,  6, 30, 20, 1'b0, 1'b0);
        run_phase(1'b1, 12,  8, 15, 1'b0, 1'b0);

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("tb_top: %0d requests accepted, %0d dumped entries checked",
                 requests, entries_checked);
        $display("tb_top: %0d repeats folded, %0d oldest entries overwritten, %0d mismatches",
                 folds, overwrites, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/btrb_pkg.sv
rtl/btrb_cell.sv
rtl/branch_trace_ring_buffer_top.sv
rtl/btrb_checker.sv
tb/sv/btrb_trace_checker.sv
tb/sv/tb_top.sv
